>>> hdl/assert_macros.svh
// assertion macros used by the heap sort engine top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define HSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hse_pkg.sv
// types, constants and microcode program of the heap sort engine
`timescale 1ns / 1ps

package hse_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;
    localparam int PC_W      = 4;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } out_t;

    // datapath actions, one per control word
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_TAKE      = 4'd1,
        OP_RD_PARENT = 4'd2,
        OP_SU_STEP   = 4'd3,
        OP_PUT       = 4'd4,
        OP_SINIT     = 4'd5,
        OP_RD_ENDS   = 4'd6,
        OP_SWAP      = 4'd7,
        OP_RD_KIDS   = 4'd8,
        OP_SD_STEP   = 4'd9,
        OP_OINIT     = 4'd10,
        OP_RD_IDX    = 4'd11,
        OP_EMIT      = 4'd12,
        OP_CLEAR     = 4'd13
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        COND_NEVER      = 4'd0,
        COND_ALWAYS     = 4'd1,
        COND_IN_DROPPED = 4'd2,
        COND_POS_ZERO   = 4'd3,
        COND_PAR_LT     = 4'd4,
        COND_NOT_LAST   = 4'd5,
        COND_CNT_LE1    = 4'd6,
        COND_LEFT_OUT   = 4'd7,
        COND_BIG_GT     = 4'd8,
        COND_LEN_GT1    = 4'd9,
        COND_CNT_ZERO   = 4'd10,
        COND_MORE       = 4'd11
    } cond_t;

    typedef enum logic [1:0] {
        STALL_NONE = 2'd0,
        STALL_IN   = 2'd1,
        STALL_OUT  = 2'd2
    } stall_t;

    // program step addresses
    localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
    localparam logic [PC_W-1:0] STEP_DISPATCH = 4'd1;
    localparam logic [PC_W-1:0] STEP_SU_TEST  = 4'd2;
    localparam logic [PC_W-1:0] STEP_SU_CMP   = 4'd3;
    localparam logic [PC_W-1:0] STEP_SU_PUT   = 4'd4;
    localparam logic [PC_W-1:0] STEP_LAST_CHK = 4'd5;
    localparam logic [PC_W-1:0] STEP_SORT     = 4'd6;
    localparam logic [PC_W-1:0] STEP_SD_RD    = 4'd7;
    localparam logic [PC_W-1:0] STEP_SD_SWAP  = 4'd8;
    localparam logic [PC_W-1:0] STEP_SD_TEST  = 4'd9;
    localparam logic [PC_W-1:0] STEP_SD_CMP   = 4'd10;
    localparam logic [PC_W-1:0] STEP_SD_PUT   = 4'd11;
    localparam logic [PC_W-1:0] STEP_OUT_INIT = 4'd12;
    localparam logic [PC_W-1:0] STEP_OUT_RD   = 4'd13;
    localparam logic [PC_W-1:0] STEP_OUT_EMIT = 4'd14;
    localparam logic [PC_W-1:0] STEP_FINISH   = 4'd15;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        stall_t          stall;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic en;
    } ctrl_t;

    typedef struct packed {
        logic took;
        logic pos_zero;
        logic par_lt;
        logic last;
        logic cnt_le1;
        logic left_out;
        logic big_gt;
        logic len_gt1;
        logic cnt_zero;
        logic more;
        logic out_free;
    } status_t;

    // control store: op, jump condition, stall source, jump target
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{op: OP_NOP, cond: COND_NEVER, stall: STALL_NONE, target: STEP_WAIT};
        case (pc)
            STEP_WAIT:     w = '{op: OP_TAKE,      cond: COND_NEVER,
                                 stall: STALL_IN,   target: STEP_WAIT};
            STEP_DISPATCH: w = '{op: OP_NOP,       cond: COND_IN_DROPPED,
                                 stall: STALL_NONE, target: STEP_LAST_CHK};
            STEP_SU_TEST:  w = '{op: OP_RD_PARENT, cond: COND_POS_ZERO,
                                 stall: STALL_NONE, target: STEP_SU_PUT};
            STEP_SU_CMP:   w = '{op: OP_SU_STEP,   cond: COND_PAR_LT,
                                 stall: STALL_NONE, target: STEP_SU_TEST};
            STEP_SU_PUT:   w = '{op: OP_PUT,       cond: COND_NEVER,
                                 stall: STALL_NONE, target: STEP_WAIT};
            STEP_LAST_CHK: w = '{op: OP_NOP,       cond: COND_NOT_LAST,
                                 stall: STALL_NONE, target: STEP_WAIT};
            STEP_SORT:     w = '{op: OP_SINIT,     cond: COND_CNT_LE1,
                                 stall: STALL_NONE, target: STEP_OUT_INIT};
            STEP_SD_RD:    w = '{op: OP_RD_ENDS,   cond: COND_NEVER,
                                 stall: STALL_NONE, target: STEP_WAIT};
            STEP_SD_SWAP:  w = '{op: OP_SWAP,      cond: COND_NEVER,
                                 stall: STALL_NONE, target: STEP_WAIT};
            STEP_SD_TEST:  w = '{op: OP_RD_KIDS,   cond: COND_LEFT_OUT,
                                 stall: STALL_NONE, target: STEP_SD_PUT};
            STEP_SD_CMP:   w = '{op: OP_SD_STEP,   cond: COND_BIG_GT,
                                 stall: STALL_NONE, target: STEP_SD_TEST};
            STEP_SD_PUT:   w = '{op: OP_PUT,       cond: COND_LEN_GT1,
                                 stall: STALL_NONE, target: STEP_SD_RD};
            STEP_OUT_INIT: w = '{op: OP_OINIT,     cond: COND_CNT_ZERO,
                                 stall: STALL_NONE, target: STEP_FINISH};
            STEP_OUT_RD:   w = '{op: OP_RD_IDX,    cond: COND_NEVER,
                                 stall: STALL_NONE, target: STEP_WAIT};
            STEP_OUT_EMIT: w = '{op: OP_EMIT,      cond: COND_MORE,
                                 stall: STALL_OUT,  target: STEP_OUT_RD};
            STEP_FINISH:   w = '{op: OP_CLEAR,     cond: COND_ALWAYS,
                                 stall: STALL_NONE, target: STEP_WAIT};
            default:       w = '{op: OP_NOP,       cond: COND_ALWAYS,
                                 stall: STALL_NONE, target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/hse_ram.sv
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps

module hse_ram #(
    parameter int WIDTH = hse_pkg::DATA_W,
    parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> hdl/hse_datapath.sv
// heap datapath: counters, sift registers, heap ram and output register
`timescale 1ns / 1ps

module hse_datapath #(
    parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  hse_pkg::ctrl_t   ctrl,
    output hse_pkg::status_t stat,
    input  hse_pkg::in_t     s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output hse_pkg::out_t    m_payload
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = AW + 2;

    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic [CW-1:0]                    len_reg, len_next;
    logic [AW-1:0]                    pos_reg, pos_next;
    logic                             dropped_reg, dropped_next;
    logic                             last_reg, last_next;
    logic                             took_reg, took_next;
    logic signed [hse_pkg::DATA_W-1:0] val_reg, val_next;
    logic                             m_valid_reg, m_valid_next;
    hse_pkg::out_t                    out_reg, out_next;

    logic                       we;
    logic [AW-1:0]              waddr, raddr_a, raddr_b;
    logic [hse_pkg::DATA_W-1:0] wdata, rdata_a, rdata_b;

    logic [AW-1:0] parent;
    logic [KW-1:0] left_w, right_w, len_ext;
    logic [CW-1:0] len_m1, pos_p1;
    logic          right_in, big_right, par_lt, big_gt, left_out, out_free;
    logic signed [hse_pkg::DATA_W-1:0] big_val;
    logic [AW-1:0] big_addr;

    hse_ram #(
        .WIDTH(hse_pkg::DATA_W),
        .DEPTH(DEPTH)
    ) u_heap (
        .clk    (aclk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rdata_a),
        .rdata_b(rdata_b)
    );

    // heap index arithmetic
    assign parent   = (pos_reg - 1'b1) >> 1;
    assign left_w   = {1'b0, pos_reg, 1'b1};
    assign right_w  = left_w + KW'(1);
    assign len_ext  = {{(KW - CW){1'b0}}, len_reg};
    assign len_m1   = len_reg - 1'b1;
    assign pos_p1   = CW'(pos_reg) + CW'(1);
    assign left_out = left_w >= len_ext;
    assign right_in = right_w < len_ext;

    // read data was addressed in the previous step
    assign par_lt    = $signed(rdata_a) < val_reg;
    assign big_right = right_in && !($signed(rdata_a) > $signed(rdata_b));
    assign big_val   = big_right ? $signed(rdata_b) : $signed(rdata_a);
    assign big_addr  = big_right ? right_w[AW-1:0] : left_w[AW-1:0];
    assign big_gt    = big_val > val_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        raddr_a = pos_reg;
        raddr_b = pos_reg;
        case (ctrl.op)
            hse_pkg::OP_RD_PARENT: raddr_a = parent;
            hse_pkg::OP_RD_ENDS: begin
                raddr_a = '0;
                raddr_b = len_m1[AW-1:0];
            end
            hse_pkg::OP_RD_KIDS: begin
                raddr_a = left_w[AW-1:0];
                raddr_b = right_w[AW-1:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        dropped_next = dropped_reg;
        last_next    = last_reg;
        took_next    = took_reg;
        val_next     = val_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        we           = 1'b0;
        waddr        = pos_reg;
        wdata        = val_reg;
        if (ctrl.en) begin
            case (ctrl.op)
                hse_pkg::OP_TAKE: begin
                    last_next = s_payload.last_in;
                    if (cnt_reg < CW'(DEPTH)) begin
                        val_next  = s_payload.value;
                        pos_next  = cnt_reg[AW-1:0];
                        cnt_next  = cnt_reg + 1'b1;
                        took_next = 1'b1;
                    end else begin
                        dropped_next = 1'b1;
                        took_next    = 1'b0;
                    end
                end
                hse_pkg::OP_SU_STEP: begin
                    if (par_lt) begin
                        we       = 1'b1;
                        wdata    = rdata_a;
                        pos_next = parent;
                    end
                end
                hse_pkg::OP_PUT: we = 1'b1;
                hse_pkg::OP_SINIT: len_next = cnt_reg;
                hse_pkg::OP_RD_ENDS: len_next = len_m1;
                hse_pkg::OP_SWAP: begin
                    // old root goes to the end, end value becomes the hole value
                    we       = 1'b1;
                    waddr    = len_reg[AW-1:0];
                    wdata    = rdata_a;
                    val_next = $signed(rdata_b);
                    pos_next = '0;
                end
                hse_pkg::OP_SD_STEP: begin
                    if (big_gt) begin
                        we       = 1'b1;
                        wdata    = big_val;
                        pos_next = big_addr;
                    end
                end
                hse_pkg::OP_OINIT: pos_next = '0;
                hse_pkg::OP_EMIT: begin
                    out_next.sorted_value = $signed(rdata_a);
                    out_next.last_out     = pos_p1 == cnt_reg;
                    out_next.overflow     = dropped_reg;
                    m_valid_next          = 1'b1;
                    pos_next              = pos_reg + 1'b1;
                end
                hse_pkg::OP_CLEAR: begin
                    cnt_next     = '0;
                    dropped_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
        took_reg <= took_next;
        val_reg  <= val_next;
        out_reg  <= out_next;
    end

    assign stat.took     = took_reg;
    assign stat.pos_zero = pos_reg == '0;
    assign stat.par_lt   = par_lt;
    assign stat.last     = last_reg;
    assign stat.cnt_le1  = cnt_reg <= CW'(1);
    assign stat.left_out = left_out;
    assign stat.big_gt   = big_gt;
    assign stat.len_gt1  = len_reg > CW'(1);
    assign stat.cnt_zero = cnt_reg == '0;
    assign stat.more     = pos_p1 != cnt_reg;
    assign stat.out_free = out_free;

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

>>> hdl/heap_sort_engine.sv
// heap sort engine top level: microcode sequencer and datapath
`timescale 1ns / 1ps

// Sorts a run of signed 32-bit values in ascending order. Values arrive one
// per transaction; the transaction with last_in set closes the run. Each value
// is written into a max-heap in a single-write, dual-read RAM and sifted up at
// once, climbing at most log2(DEPTH) levels toward the root; a dropped value
// skips the sift. After the last value the engine swaps the root with the heap
// end and sifts down once per stored value but the first, each pass sinking
// the hole to a leaf or stopping above one. The engine then sends the run
// smallest first, reading each result from the heap RAM before it emits it,
// while the result channel keeps up, with last_out on the largest. Each sift
// is a read-compare-write loop around the heap RAM: one registered read, then
// one compare and write per level. s_ready is high only while the sequencer
// waits for a value. Values beyond DEPTH are dropped and overflow is set on
// every result of that run. A sequencer steps through a 16-word control
// program.
module heap_sort_engine #(
    parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hse_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output hse_pkg::out_t m_payload
);

`include "assert_macros.svh"

    logic [hse_pkg::PC_W-1:0] pc_reg, pc_next;
    hse_pkg::ucode_t          word;
    hse_pkg::ctrl_t           ctrl;
    hse_pkg::status_t         stat;
    logic                     stall, jump;

    assign word = hse_pkg::ucode_rom(pc_reg);

    assign stall = (word.stall == hse_pkg::STALL_IN && !s_valid) ||
                   (word.stall == hse_pkg::STALL_OUT && !stat.out_free);

    always_comb begin
        case (word.cond)
            hse_pkg::COND_NEVER:      jump = 1'b0;
            hse_pkg::COND_ALWAYS:     jump = 1'b1;
            hse_pkg::COND_IN_DROPPED: jump = !stat.took;
            hse_pkg::COND_POS_ZERO:   jump = stat.pos_zero;
            hse_pkg::COND_PAR_LT:     jump = stat.par_lt;
            hse_pkg::COND_NOT_LAST:   jump = !stat.last;
            hse_pkg::COND_CNT_LE1:    jump = stat.cnt_le1;
            hse_pkg::COND_LEFT_OUT:   jump = stat.left_out;
            hse_pkg::COND_BIG_GT:     jump = stat.big_gt;
            hse_pkg::COND_LEN_GT1:    jump = stat.len_gt1;
            hse_pkg::COND_CNT_ZERO:   jump = stat.cnt_zero;
            hse_pkg::COND_MORE:       jump = stat.more;
            default:                  jump = 1'b1;
        endcase
    end

    always_comb begin
        if (stall) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = word.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= hse_pkg::STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign s_ready = word.stall == hse_pkg::STALL_IN;
    assign ctrl.op = word.op;
    assign ctrl.en = !stall;

    hse_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    // a new result only comes from an executed emit step
    `HSE_ASSERT_IMPL(a_emit_src, aclk, aresetn, $rose(m_valid),
        $past(ctrl.en && ctrl.op == hse_pkg::OP_EMIT),
        "result register loaded outside emit step")
    // a blocked output holds the program at the emit step
    `HSE_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        word.stall == hse_pkg::STALL_OUT && !stat.out_free,
        pc_reg == hse_pkg::STEP_OUT_EMIT, "sequencer moved while result channel stalled")
    // the run bookkeeping is cleared after the finish step
    `HSE_ASSERT_NEXT(a_run_clear, aclk, aresetn, pc_reg == hse_pkg::STEP_FINISH,
        stat.cnt_zero && pc_reg == hse_pkg::STEP_WAIT, "entry count not cleared at end of run")

endmodule

>>> verif/tb.sv
// testbench for heap_sort_engine: directed and random runs checked against a sorted-run predictor
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH       = hse_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;

    typedef struct {
        hse_pkg::in_t item;
        bit           drain_first;
    } feed_t;

    typedef enum logic [1:0] {
        RDY_FULL     = 2'd0,
        RDY_MOST     = 2'd1,
        RDY_SPARSE   = 2'd2,
        RDY_PERIODIC = 2'd3
    } rdy_mode_t;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    hse_pkg::in_t  s_payload = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    hse_pkg::out_t m_payload;

    feed_t              feed_q[$];
    hse_pkg::out_t      sorted_q[$];
    logic signed [31:0] run_vals[$];
    bit                 run_dropped = 1'b0;

    int drv_cnt     = 0;
    int acc_cnt     = 0;
    int rcv_cnt     = 0;
    int err_cnt     = 0;
    int cycle_cnt   = 0;
    int gap_left    = 0;
    int burst_left  = 8;
    int hold_left   = 0;
    int next_hold   = 20;
    int mode_left   = 0;
    rdy_mode_t rdy_mode = RDY_FULL;

    heap_sort_engine #(.DEPTH(DEPTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // keeps the current run sorted as it arrives; a final transaction releases it
    function automatic void predict_sorted(hse_pkg::in_t t);
        logic signed [31:0] v;
        hse_pkg::out_t      r;
        int                 k;
        v = $signed(t.value);
        if (run_vals.size() < DEPTH) begin
            k = 0;
            while (k < run_vals.size() && run_vals[k] <= v)
                k++;
            run_vals.insert(k, v);
        end else begin
            run_dropped = 1'b1;
        end
        if (t.last_in) begin
            foreach (run_vals[i]) begin
                r.sorted_value = run_vals[i];
                r.last_out     = (i == run_vals.size() - 1);
                r.overflow     = run_dropped;
                sorted_q.push_back(r);
            end
            run_vals.delete();
            run_dropped = 1'b0;
        end
    endfunction

    function automatic void push_item(logic [31:0] v, logic last, bit drain);
        feed_t f;
        f.item.value   = v;
        f.item.last_in = last;
        f.drain_first  = drain;
        feed_q.push_back(f);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $unsigned($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result check, then prediction of the transaction taken at this edge
    always @(posedge aclk) begin
        hse_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            rcv_cnt <= rcv_cnt + 1;
            if (sorted_q.size() == 0) begin
                $display("%0t: expected no result, got value %0d last %0b overflow %0b",
                         $time, $signed(m_payload.sorted_value), m_payload.last_out,
                         m_payload.overflow);
                err_cnt++;
            end else begin
                want = sorted_q.pop_front();
                if (m_payload.sorted_value !== want.sorted_value) begin
                    $display("%0t: sorted_value expected %0d got %0d", $time,
                             $signed(want.sorted_value), $signed(m_payload.sorted_value));
                    err_cnt++;
                end
                if (m_payload.last_out !== want.last_out) begin
                    $display("%0t: last_out expected %0b got %0b", $time,
                             want.last_out, m_payload.last_out);
                    err_cnt++;
                end
                if (m_payload.overflow !== want.overflow) begin
                    $display("%0t: overflow expected %0b got %0b", $time,
                             want.overflow, m_payload.overflow);
                    err_cnt++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            predict_sorted(s_payload);
            acc_cnt <= acc_cnt + 1;
        end
    end

    // driver: bursts and gaps; a marked transaction waits until all results are in
    always @(negedge aclk) begin
        if (aresetn && drv_cnt == acc_cnt) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (feed_q.size() > 0 &&
                         !(feed_q[0].drain_first && sorted_q.size() > 0)) begin
                s_payload <= feed_q[0].item;
                s_valid   <= 1'b1;
                drv_cnt   <= drv_cnt + 1;
                void'(feed_q.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall modes, plus a long hold-off now and then
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (m_valid && rcv_cnt >= next_hold) begin
                hold_left <= HOLD_CYCLES;
                next_hold <= next_hold + 170;
                m_ready   <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rdy_mode  <= rdy_mode_t'($urandom_range(0, 3));
                    mode_left <= $urandom_range(20, 120);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (rdy_mode)
                    RDY_FULL:   m_ready <= 1'b1;
                    RDY_MOST:   m_ready <= ($urandom_range(0, 3) != 0);
                    RDY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:    m_ready <= (cycle_cnt % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        int  lens[$];
        int  total;
        int  n;
        bit  drain;

        // single-value runs at both extremes
        push_item(32'h7FFF_FFFF, 1'b1, 1'b0);
        push_item(32'h8000_0000, 1'b1, 1'b0);
        // mixed extremes and bit patterns
        push_item(32'h7FFF_FFFF, 1'b0, 1'b0);
        push_item(32'h8000_0000, 1'b0, 1'b0);
        push_item(32'h0000_0000, 1'b0, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0, 1'b0);
        push_item(32'h0000_0001, 1'b0, 1'b0);
        push_item(32'h5555_5555, 1'b0, 1'b0);
        push_item(32'hAAAA_AAAA, 1'b0, 1'b0);
        push_item(32'h0000_0000, 1'b1, 1'b0);
        // ties
        push_item(32'd7, 1'b0, 1'b0);
        push_item(32'd7, 1'b0, 1'b0);
        push_item(-32'sd3, 1'b0, 1'b0);
        push_item(32'd7, 1'b0, 1'b0);
        push_item(-32'sd3, 1'b1, 1'b0);
        // already descending, then already ascending
        push_item(32'd40, 1'b0, 1'b1);
        push_item(32'd30, 1'b0, 1'b0);
        push_item(32'd20, 1'b0, 1'b0);
        push_item(32'd10, 1'b1, 1'b0);
        push_item(-32'sd10, 1'b0, 1'b0);
        push_item(-32'sd5, 1'b0, 1'b0);
        push_item(32'd5, 1'b0, 1'b0);
        push_item(32'd10, 1'b1, 1'b0);

        // mostly short runs; one exactly full, one dropping its final value,
        // one dropping several values
        total = 0;
        while (total < 130) begin
            n = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(2, 12);
            lens.push_back(n);
            total += n;
        end
        lens.insert($urandom_range(0, lens.size()), DEPTH);
        lens.insert($urandom_range(0, lens.size()), DEPTH + 1);
        lens.insert($urandom_range(0, lens.size()), DEPTH + 3);
        foreach (lens[r]) begin
            drain = (r == 0) || ($urandom_range(0, 9) == 0);
            for (int k = 0; k < lens[r]; k++)
                push_item(rand_value(), k == lens[r] - 1, drain && k == 0);
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (feed_q.size() > 0 || drv_cnt != acc_cnt || sorted_q.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
